// ----- src/range_sum_tree_defines.svh -----
// ----------------------------------------------------------------------------
// range_sum_tree_defines.svh
// Assertion macros shared by the range sum tree checkers.
// ----------------------------------------------------------------------------
`ifndef RANGE_SUM_TREE_DEFINES_SVH
`define RANGE_SUM_TREE_DEFINES_SVH

// Same-cycle implication, disabled while rst_n is low.
`define RSUM_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define RSUM_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- src/rsum_pkg.sv -----
// ----------------------------------------------------------------------------
// rsum_pkg
// Widths, codes, types and helpers for the range sum tree.
// ----------------------------------------------------------------------------
package rsum_pkg;

    // Leaf count, a power of two. Leaf p sits at node LEAVES + p, root at 1.
    localparam int LEAVES = 1024;
    localparam int NODES  = 2 * LEAVES;
    localparam int LEAF_W = $clog2(LEAVES);
    localparam int NODE_W = LEAF_W + 1;   // node address
    localparam int QPTR_W = LEAF_W + 2;   // query pointer, holds NODES itself

    // Item fields
    localparam int LEFT_W  = 10;
    localparam int RIGHT_W = 11;
    localparam int VAL_W   = 16;
    localparam int RS_W    = 26;

    // Width of any subtree sum
    localparam int SUM_W = VAL_W + LEAF_W;

    localparam logic [RS_W-1:0] RS_MAX = {RS_W{1'b1}};

    // Action codes
    localparam logic ACT_SET   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SET,
        S_QRY
    } t_state;

    // Access request from the tree walker to the node store
    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [SUM_W-1:0]  wdata;
        logic [NODE_W-1:0] raddr;
    } t_mem_req;

    // Clip a range sum to the result field.
    function automatic logic [RS_W-1:0] sat_sum(input logic [SUM_W-1:0] s);
        if (SUM_W > RS_W && s > SUM_W'(RS_MAX)) begin
            return RS_MAX;
        end
        return RS_W'(s);
    endfunction

endpackage

// ----- src/rsum_ram.sv -----
// ----------------------------------------------------------------------------
// rsum_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rsum_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/rsum_walk.sv -----
// ----------------------------------------------------------------------------
// rsum_walk
// Tree walker: clearing pass, leaf set with ancestor update, range query.
// ----------------------------------------------------------------------------
module rsum_walk (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic [rsum_pkg::LEFT_W-1:0]  i_left_index,
    input  logic [rsum_pkg::RIGHT_W-1:0] i_right_end,
    input  logic [rsum_pkg::VAL_W-1:0]   i_leaf_value,
    input  logic                       i_out_free,
    output logic                       o_res_valid,
    output logic [rsum_pkg::RS_W-1:0]  o_res_sum,
    output rsum_pkg::t_mem_req         o_mem,
    input  logic [rsum_pkg::SUM_W-1:0] i_rdata
);

    import rsum_pkg::*;

    t_state             r_state, n_state;
    logic [NODE_W-1:0]  r_node, n_node;
    logic [SUM_W-1:0]   r_acc, n_acc;
    logic [QPTR_W-1:0]  r_lo, n_lo;
    logic [QPTR_W-1:0]  r_hi, n_hi;
    logic               r_pend, n_pend;

    logic [NODE_W-1:0]  leaf_node;
    logic [NODE_W-1:0]  parent;
    logic [SUM_W-1:0]   up_sum;
    logic [SUM_W-1:0]   q_sum;
    logic [QPTR_W-1:0]  lo_inc;
    logic [QPTR_W-1:0]  hi_dec;

    assign leaf_node = NODE_W'(LEAVES) + NODE_W'(i_left_index);
    assign parent    = r_node >> 1;
    assign up_sum    = r_acc + i_rdata;
    assign q_sum     = r_acc + (r_pend ? i_rdata : SUM_W'(0));
    assign lo_inc    = r_lo + QPTR_W'(1);
    assign hi_dec    = r_hi - QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_node  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
    end

    always_comb begin
        n_state     = r_state;
        n_node      = r_node;
        n_acc       = r_acc;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pend      = r_pend;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_res_sum   = sat_sum(q_sum);
        o_mem.we    = 1'b0;
        o_mem.waddr = r_node;
        o_mem.wdata = '0;
        o_mem.raddr = r_node;

        unique case (r_state)
            S_CLEAR: begin
                // r_node doubles as the sweep address
                o_mem.we    = 1'b1;
                o_mem.waddr = r_node;
                n_node      = r_node + NODE_W'(1);
                if (r_node == NODE_W'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_action == ACT_SET) begin
                        if (32'(i_left_index) < LEAVES) begin
                            // write leaf, fetch its sibling for the first sum
                            o_mem.we    = 1'b1;
                            o_mem.waddr = leaf_node;
                            o_mem.wdata = SUM_W'(i_leaf_value);
                            o_mem.raddr = leaf_node ^ NODE_W'(1);
                            n_node      = leaf_node;
                            n_acc       = SUM_W'(i_leaf_value);
                            n_state     = S_SET;
                        end
                    end else begin
                        n_acc  = '0;
                        n_pend = 1'b0;
                        if (32'(i_left_index) >= LEAVES) begin
                            n_lo = QPTR_W'(NODES);
                        end else begin
                            n_lo = QPTR_W'(LEAVES) + QPTR_W'(i_left_index);
                        end
                        if (32'(i_right_end) > LEAVES) begin
                            n_hi = QPTR_W'(NODES);
                        end else begin
                            n_hi = QPTR_W'(LEAVES) + QPTR_W'(i_right_end);
                        end
                        n_state = S_QRY;
                    end
                end
            end
            S_SET: begin
                // one level per cycle: parent = node + sibling
                o_mem.we    = 1'b1;
                o_mem.waddr = parent;
                o_mem.wdata = up_sum;
                o_mem.raddr = parent ^ NODE_W'(1);
                n_node      = parent;
                n_acc       = up_sum;
                if (parent == NODE_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_QRY: begin
                n_acc = q_sum;
                if (r_lo < r_hi) begin
                    if (r_lo[0]) begin
                        o_mem.raddr = r_lo[NODE_W-1:0];
                        n_pend      = 1'b1;
                        if (r_hi[0]) begin
                            n_lo = lo_inc;
                        end else begin
                            n_lo = lo_inc >> 1;
                            n_hi = r_hi >> 1;
                        end
                    end else if (r_hi[0]) begin
                        o_mem.raddr = hi_dec[NODE_W-1:0];
                        n_pend      = 1'b1;
                        n_lo        = r_lo >> 1;
                        n_hi        = hi_dec >> 1;
                    end else begin
                        n_pend = 1'b0;
                        n_lo   = r_lo >> 1;
                        n_hi   = r_hi >> 1;
                    end
                end else begin
                    // fold the last read, then hand off once the output is free
                    n_pend = 1'b0;
                    if (i_out_free) begin
                        o_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/range_sum_tree.sv -----
// Items: a set writes its leaf and then each ancestor up to the root and gives no
// result; a query climbs the tree from both ends of its range to give one result.
// Throughput: one item at a time, set by the single read port of the node store.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every node
// of the node store, with the input held not ready.
// ----------------------------------------------------------------------------
// range_sum_tree
// Bottom-up segment tree of range sums kept in one node RAM.
// ----------------------------------------------------------------------------
module range_sum_tree (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_action,
    input  logic [rsum_pkg::LEFT_W-1:0]  i_left_index,
    input  logic [rsum_pkg::RIGHT_W-1:0] i_right_end,
    input  logic [rsum_pkg::VAL_W-1:0]   i_leaf_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rsum_pkg::RS_W-1:0]    o_range_sum
);

    import rsum_pkg::*;

    // Node store: node n at address n, address 0 unused. Only the walker
    // writes it; a set writes one node per cycle from leaf to root, reading the
    // sibling of the node written in the same cycle, so a set's read and write
    // never collide. Items run one after another, so a read always sees the
    // last write of the previous item.
    t_mem_req           mem_req;
    logic [SUM_W-1:0]   mem_rdata;

    // Walker result, handed to the output register
    logic               res_valid;
    logic [RS_W-1:0]    res_sum;
    logic               out_free;

    // Output register: holds one result so the walker can take the next item
    // while the result still waits for its transfer.
    logic               r_out_valid;
    logic [RS_W-1:0]    r_out_sum;

    assign out_free = !r_out_valid || i_ready;

    rsum_walk u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_left_index (i_left_index),
        .i_right_end  (i_right_end),
        .i_leaf_value (i_leaf_value),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res_sum    (res_sum),
        .o_mem        (mem_req),
        .i_rdata      (mem_rdata)
    );

    rsum_ram #(
        .WIDTH (SUM_W),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // Load on a finished query, drop after the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_sum <= res_sum;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_range_sum = r_out_sum;

endmodule

// ----- src/range_sum_tree_chk.sv -----
// ----------------------------------------------------------------------------
// range_sum_tree_chk
// Port-level checks for the range sum tree, bound to the top level.
// ----------------------------------------------------------------------------
`include "range_sum_tree_defines.svh"

module range_sum_tree_chk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic                         i_action,
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic [rsum_pkg::RS_W-1:0]    o_range_sum
);

    // Reset starts the clearing pass with no result pending.
    `RSUM_ASSERT_NXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_ready && !o_valid, "not quiet after reset")

    // No result rises at once after an item's transfer.
    `RSUM_ASSERT_NXT(a_no_instant_result, i_clk, i_rst_n, i_valid && o_ready, !$rose(o_valid), "result too early")

    // A stalled result holds.
    `RSUM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_range_sum), "result dropped while stalled")

    // A set accepted with no result pending is not followed at once by a result.
    `RSUM_ASSERT_NXT(a_set_silent, i_clk, i_rst_n, i_valid && o_ready && !i_action && !o_valid, !o_valid, "set produced a result")

endmodule

bind range_sum_tree range_sum_tree_chk u_chk (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the range sum tree. Leaf writes and range queries
// are sent over the input channel. A local copy of the node tree predicts
// every range sum, and each result transfer is compared against it in order.
// Coverage: fixed corner cases, a full load of all leaves, a random mix with a
// forced drain, and a closing run at full rate.
// ----------------------------------------------------------------------------
module tb_top;

    import rsum_pkg::*;

    // Settle time after the last result: long enough, with margin, for a leaf
    // write still walking the tree to finish.
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_action;
    logic [LEFT_W-1:0]   i_left_index;
    logic [RIGHT_W-1:0]  i_right_end;
    logic [VAL_W-1:0]    i_leaf_value;
    logic                o_valid;
    logic                i_ready;
    logic [RS_W-1:0]     o_range_sum;

    // Local node tree: leaf p at LEAVES + p, root at node 1
    bit [31:0]           model_nodes [0:NODES-1];
    logic [RS_W-1:0]     pending_sums [$];

    bit                  idle_enable;
    int                  mismatch_count;
    int                  leaf_writes;
    int                  queries_sent;
    int                  sums_checked;
    logic [RS_W-1:0]     largest_sum;

    range_sum_tree dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_left_index (i_left_index),
        .i_right_end  (i_right_end),
        .i_leaf_value (i_leaf_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_range_sum  (o_range_sum)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Write one leaf, then recompute every ancestor up to the root.
    function automatic void write_leaf(input logic [LEFT_W-1:0] pos,
                                       input logic [VAL_W-1:0] value);
        int unsigned node;
        if (pos >= LEAVES) begin
            return;
        end
        node = LEAVES + pos;
        model_nodes[node] = value;
        while (node > 1) begin
            node = node >> 1;
            model_nodes[node] = model_nodes[2*node] + model_nodes[2*node+1];
        end
    endfunction

    // Sum of leaves in [lo, hi), climbing the tree from both ends.
    function automatic logic [RS_W-1:0] range_total(input logic [LEFT_W-1:0] lo_in,
                                                    input logic [RIGHT_W-1:0] hi_in);
        longint unsigned acc;
        int unsigned     lo;
        int unsigned     hi;
        acc = 0;
        lo  = lo_in;
        hi  = hi_in;
        // Clamp the end to the leaf count; empty or reversed gives zero
        if (hi > LEAVES) begin
            hi = LEAVES;
        end
        if (lo >= hi) begin
            return '0;
        end
        lo += LEAVES;
        hi += LEAVES;
        while (lo < hi) begin
            if (lo[0]) begin
                acc += model_nodes[lo];
                lo++;
            end
            if (hi[0]) begin
                hi--;
                acc += model_nodes[hi];
            end
            lo = lo >> 1;
            hi = hi >> 1;
        end
        // Saturate to the result field
        if (acc > RS_MAX) begin
            acc = RS_MAX;
        end
        return acc[RS_W-1:0];
    endfunction

    // Leaf values lean high so large ranges reach the top bits of the sum.
    function automatic logic [VAL_W-1:0] random_leaf_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end else if (pick < 4) begin
            return VAL_W'($urandom_range(0, 2**VAL_W - 1));
        end
        return VAL_W'($urandom_range(2**VAL_W - 2**(VAL_W-2), 2**VAL_W - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------------

    // Send one item. Called in step with the clock; returns once the transfer
    // has happened, with valid still high so the next item can follow back to
    // back.
    task automatic send_item(input logic act,
                             input logic [LEFT_W-1:0] left,
                             input logic [RIGHT_W-1:0] right,
                             input logic [VAL_W-1:0] value);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
        end
        // Drop valid for an idle burst before presenting the item
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_left_index <= left;
        i_right_end  <= right;
        i_leaf_value <= value;
        // Hold the payload until the block takes it
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (act == ACT_SET) begin
            leaf_writes++;
            write_leaf(left, value);
        end else begin
            queries_sent++;
            pending_sums = {pending_sums, range_total(left, right)};
        end
    endtask

    task automatic send_query(input int lo, input int hi);
        send_item(ACT_QUERY, LEFT_W'(lo), RIGHT_W'(hi), random_leaf_value());
    endtask

    // One random item: mostly leaf writes and well-formed ranges, some short
    // ranges, some ends past the last leaf, and some raw noise.
    task automatic send_random_item();
        logic [LEFT_W-1:0]  lo;
        logic [RIGHT_W-1:0] hi;
        int                 pick;
        int                 span;
        lo   = LEFT_W'($urandom_range(0, LEAVES - 1));
        hi   = RIGHT_W'($urandom_range(0, 2**RIGHT_W - 1));
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            send_item(ACT_SET, lo, hi, random_leaf_value());
        end else begin
            if (pick < 72) begin
                hi = RIGHT_W'(lo + 1 + $urandom_range(0, LEAVES - 1 - lo));
            end else if (pick < 82) begin
                span = $urandom_range(0, 8);
                hi = RIGHT_W'((lo + span > LEAVES) ? LEAVES : lo + span);
            end else if (pick < 90) begin
                hi = RIGHT_W'($urandom_range(LEAVES, 2**RIGHT_W - 1));
            end
            send_item(ACT_QUERY, lo, hi, random_leaf_value());
        end
    endtask

    // Stop sending and hold until every predicted sum has come back, then let
    // any leaf write still walking the tree finish.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Output channel: stall in random bursts, check each transfer in order
    // ------------------------------------------------------------------------

    initial begin : sink_stall
        int hold;
        hold = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 15);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic report_failure(input string what,
                                  input logic [RS_W-1:0] want,
                                  input logic [RS_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : sum_check
        logic [RS_W-1:0] want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_sums.size() == 0) begin
                report_failure("unexpected range_sum", '0, o_range_sum);
            end else begin
                want = pending_sums.pop_front();
                sums_checked++;
                if (want > largest_sum) begin
                    largest_sum = want;
                end
                if (o_range_sum !== want) begin
                    report_failure("range_sum mismatch", want, o_range_sum);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner cases: empty tree, edge leaves, clamped, empty and reversed ranges.
    // Leaf positions past the end and a saturating sum cannot occur at these
    // widths, so they are not targeted.
    task automatic test_corner_ranges();
        send_query(0, LEAVES);
        send_query(0, 2**RIGHT_W - 1);
        send_item(ACT_SET, LEFT_W'(0), '0, '1);
        send_item(ACT_SET, LEFT_W'(LEAVES - 1), '0, '1);
        send_item(ACT_SET, LEFT_W'(LEAVES / 2), '1, VAL_W'(16'h8000));
        send_item(ACT_SET, LEFT_W'(LEAVES / 2 - 1), '0, VAL_W'(16'h0001));
        send_item(ACT_SET, LEFT_W'(1), '0, VAL_W'(16'haaaa));
        send_item(ACT_SET, LEFT_W'(2), '0, VAL_W'(16'h5555));
        send_query(0, LEAVES);
        send_query(0, 2**RIGHT_W - 1);
        send_query(LEAVES - 1, 2**RIGHT_W - 1);
        send_query(LEAVES - 1, LEAVES);
        send_query(0, 1);
        send_query(5, 5);
        send_query(LEAVES - 1, 0);
        send_query(LEAVES / 2, LEAVES / 2 - 1);
        send_query(LEAVES / 2 - 1, LEAVES / 2 + 1);
        send_query(1, 3);
        send_query(0, 0);
        send_item(ACT_SET, LEFT_W'(0), '0, '0);
        send_query(0, 2);
        send_item(ACT_SET, LEFT_W'(LEAVES - 1), '1, VAL_W'(16'h1234));
        send_query(LEAVES - 2, LEAVES);
        send_query(LEAVES - 1, LEAVES - 1);
    endtask

    // Write every leaf in order, with a random item every 32 writes, then
    // read back the whole tree.
    task automatic test_full_load();
        for (int p = 0; p < LEAVES; p++) begin
            send_item(ACT_SET, LEFT_W'(p), RIGHT_W'($urandom_range(0, 2**RIGHT_W - 1)),
                      random_leaf_value());
            if (p % 32 == 31) begin
                send_random_item();
            end
        end
        send_query(0, LEAVES);
        send_query(0, 2**RIGHT_W - 1);
    endtask

    // Random mix with a full drain halfway through.
    task automatic test_random_mix();
        repeat (25) send_random_item();
        wait_for_results();
        repeat (25) send_random_item();
    endtask

    // Back-to-back traffic with no stalls on either side.
    task automatic test_full_rate();
        idle_enable = 1'b0;
        repeat (20) send_random_item();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin : main_seq
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_action       <= ACT_SET;
        i_left_index   <= '0;
        i_right_end    <= '0;
        i_leaf_value   <= '0;
        idle_enable    = 1'b1;
        mismatch_count = 0;
        leaf_writes    = 0;
        queries_sent   = 0;
        sums_checked   = 0;
        largest_sum    = '0;
        foreach (model_nodes[n]) begin
            model_nodes[n] = '0;
        end
        repeat (7) @(posedge i_clk);
        // Release reset; the block clears its store before taking transfers
        i_rst_n <= 1'b1;

        test_corner_ranges();
        test_full_load();
        test_random_mix();
        test_full_rate();
        wait_for_results();

        if (pending_sums.size() != 0) begin
            report_failure("missing range_sum", pending_sums[0], '0);
        end
        $display("Run covered %0d leaf writes and %0d range queries (%0d sums checked).",
                 leaf_writes, queries_sent, sums_checked);
        $display("Includes a full leaf load, clamped, empty and reversed ranges; largest %0d.",
                 largest_sum);
        if (mismatch_count == 0) begin
            $display("** range_sum_tree: PASSED **");
        end else begin
            $display("** range_sum_tree: FAILED **");
        end
        $finish;
    end

    // Generous cap: reset clear plus every item at its slowest, many times over
    initial begin : watchdog
        #6ms;
        $display("** range_sum_tree: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/rsum_pkg.sv
src/rsum_ram.sv
src/rsum_walk.sv
src/range_sum_tree.sv
src/range_sum_tree_chk.sv
tb/tb_top.sv
